@@ rtl/cfcf_pkg.sv @@
// ============================================================================
// cfcf_pkg: shared types and arithmetic for the contact force pipeline
// Saturating Q16.16 helpers, square root and divider step functions, the
// per-stage context record and the stage schedule.
// ============================================================================
package cfcf_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  typedef logic signed [WORD_WIDTH-1:0] q_t;

  localparam q_t QMAX = 32'sh7fff_ffff;
  localparam q_t QMIN = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [2:0] REG_KN = 3'd0;
  localparam logic [2:0] REG_GN = 3'd1;
  localparam logic [2:0] REG_KT = 3'd2;
  localparam logic [2:0] REG_GT = 3'd3;
  localparam logic [2:0] REG_MU = 3'd4;
  localparam logic [2:0] REG_DT = 3'd5;

  localparam logic [30:0] DT_RESET = 31'd655;

  // Bits of quotient for a unit-vector division and for the general one
  localparam int NB = 17;
  localparam int XB = 32;
  localparam int SQ_STEPS = 32;

  // Stage schedule: op k turns context k into context k+1
  localparam int K_SQ   = 0;
  localparam int K_SA   = K_SQ + 1;
  localparam int K_PEN  = K_SA + SQ_STEPS + 1;
  localparam int K_NRM  = K_PEN + NB + 1;
  localparam int K_ARM  = K_NRM + 1;
  localparam int K_ARN  = K_ARM + 1;
  localparam int K_WMU  = K_ARN + 1;
  localparam int K_RV   = K_WMU + 1;
  localparam int K_RVM  = K_RV + 1;
  localparam int K_RN   = K_RVM + 1;
  localparam int K_VN   = K_RN + 1;
  localparam int K_VT   = K_VN + 1;
  localparam int K_SP   = K_VT + 1;
  localparam int K_SPJ  = K_SP + 1;
  localparam int K_FM   = K_SPJ + 1;
  localparam int K_F    = K_FM + 1;
  localparam int K_FSQ  = K_F + 1;
  localparam int K_SB   = K_FSQ + 1;
  localparam int K_P1   = K_SB + SQ_STEPS + 1;
  localparam int K_P2   = K_P1 + 1;
  localparam int K_P3   = K_P2 + 1;
  localparam int K_P4   = K_P3 + 1;
  localparam int K_P5   = K_P4 + 1;
  localparam int K_P6   = K_P5 + 1;
  localparam int K_UX   = K_P3 + NB + 1;
  localparam int K_CF   = K_UX + 1;
  localparam int K_DD   = K_P6 + SQ_STEPS + 1;
  localparam int K_X    = K_DD + XB + 1;
  localparam int K_XS   = K_X + 1;
  localparam int K_KT   = K_XS + 1;
  localparam int K_LF   = K_KT + 1;
  localparam int K_SEL  = K_LF + 1;
  localparam int K_T    = K_SEL + 1;
  localparam int K_TM   = K_T + 1;
  localparam int K_TQ   = K_TM + 1;
  localparam int N_OPS  = K_TQ + 1;

  typedef struct packed {
    q_t kn;
    q_t gn;
    q_t kt;
    q_t gt;
    q_t mu;
    q_t dt;
    q_t hgn;
    q_t hgt;
  } cfg_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [31:0] root;
    logic [35:0] rem;
  } sqs_t;

  typedef struct packed {
    logic [47:0] num;
    logic [31:0] dv;
    logic [32:0] rem;
    logic [31:0] quo;
    logic        ovf;
  } dvs_t;

  typedef struct packed {
    q_t ox; q_t oy; q_t r0; q_t r1; q_t vx; q_t vy; q_t w0; q_t w1; q_t sx; q_t sy;
    logic [63:0] p0; logic [63:0] p1; logic [63:0] p2;
    logic [63:0] p3; logic [63:0] p4; logic [63:0] p5;
    sqs_t sq0; sqs_t sq1; sqs_t sq2;
    dvs_t dv0; dvs_t dv1;
    q_t rs; q_t d; q_t pen; q_t nx; q_t ny; q_t l0; q_t l1;
    q_t a0x; q_t a0y; q_t a1x; q_t a1y; q_t b0; q_t b1;
    q_t e0; q_t e1; q_t e2; q_t e3; q_t rvx; q_t rvy;
    q_t f0; q_t f1; q_t f2; q_t f3; q_t rn; q_t vnx; q_t vny;
    q_t g0; q_t g1; q_t vtx; q_t vty; q_t sn; q_t h0; q_t h1; q_t kp;
    q_t j0; q_t j1; q_t j2; q_t j3; q_t j4; q_t j5; q_t hvx; q_t hvy;
    q_t fnx; q_t fny; q_t ffx; q_t ffy; q_t o0; q_t o1;
    q_t u0; q_t u1; q_t u2; q_t u3; q_t u4; q_t u5; q_t u6; q_t u7;
    q_t k0; q_t k1; q_t k2; q_t k3; q_t dss; q_t dvs; q_t dvv; q_t dff;
    q_t ft; q_t nvt; q_t mraw; q_t hv; q_t qa; q_t qb; q_t c1; q_t c2;
    q_t mufn; q_t qc; q_t ac; q_t bb; q_t ac2; q_t ac4; q_t ux; q_t uy;
    q_t cfx; q_t cfy; q_t xv; q_t lsx; q_t lsy; q_t y0; q_t y1; q_t lfx; q_t lfy;
    q_t tx; q_t ty; q_t z0; q_t z1; q_t z2; q_t z3; q_t tq0; q_t tq1;
    logic dpos; logic fneg; logic clr; logic lim; logic qpos; logic nsg;
  } ctx_t;

  // Signed result from sign and magnitude, saturated
  function automatic q_t sat_mag(logic neg, logic [63:0] m);
    q_t r;
    if (!neg) begin
      r = (m > 64'h7fff_ffff) ? QMAX : q_t'(m[31:0]);
    end else if (m >= 64'h8000_0000) begin
      r = QMIN;
    end else begin
      r = -q_t'(m[31:0]);
    end
    return r;
  endfunction

  function automatic q_t sat33(logic [32:0] s);
    q_t r;
    if (s[32] != s[31]) begin
      r = s[32] ? QMIN : QMAX;
    end else begin
      r = q_t'(s[31:0]);
    end
    return r;
  endfunction

  function automatic q_t qadd(q_t a, q_t b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic q_t qsub(q_t a, q_t b);
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  function automatic q_t qneg(q_t a);
    return qsub('0, a);
  endfunction

  function automatic logic [31:0] mag32(q_t a);
    logic [31:0] u;
    u = a;
    return a[31] ? (~u + 32'd1) : u;
  endfunction

  function automatic logic [63:0] sq64(q_t a);
    logic [63:0] m;
    m = {32'b0, mag32(a)};
    return m * m;
  endfunction

  function automatic q_t qmul(q_t a, q_t b);
    logic [63:0] p;
    p = {32'b0, mag32(a)} * {32'b0, mag32(b)};
    return sat_mag(a[31] ^ b[31], p >> FRAC_BITS);
  endfunction

  function automatic sqs_t sqrt_init(logic [63:0] rad);
    sqs_t s;
    s.rad  = rad;
    s.root = '0;
    s.rem  = '0;
    return s;
  endfunction

  // One result bit of the digit-by-digit square root
  function automatic sqs_t sqrt_step(sqs_t s);
    logic [35:0] r2;
    logic [35:0] tr;
    sqs_t n;
    r2 = {s.rem[33:0], s.rad[63:62]};
    tr = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[61:0], 2'b00};
    if (r2 >= tr) begin
      n.rem  = r2 - tr;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = r2;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic q_t root_val(sqs_t s);
    return sat_mag(1'b0, {32'b0, s.root});
  endfunction

  // Restoring divider set up for qb quotient bits of (a << 16) / d
  function automatic dvs_t div_init(logic [31:0] a, logic [31:0] d, int qb);
    logic [47:0] nn;
    dvs_t s;
    nn    = {a, 16'b0};
    s.rem = 33'(nn >> qb);
    s.num = nn << (48 - qb);
    s.dv  = d;
    s.quo = '0;
    s.ovf = (33'(nn >> qb) >= {1'b0, d});
    return s;
  endfunction

  function automatic dvs_t div_step(dvs_t s);
    logic [33:0] r2;
    dvs_t n;
    n = s;
    r2 = {s.rem, s.num[47]};
    n.num = {s.num[46:0], 1'b0};
    if (r2 >= {2'b00, s.dv}) begin
      n.rem = 33'(r2 - {2'b00, s.dv});
      n.quo = {s.quo[30:0], 1'b1};
    end else begin
      n.rem = r2[32:0];
      n.quo = {s.quo[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic q_t div_val(logic neg, dvs_t s);
    return sat_mag(neg, s.ovf ? 64'h1_0000_0000 : {32'b0, s.quo});
  endfunction

  // Work of pipeline stage k
  function automatic ctx_t stage_op(int k, ctx_t c, cfg_t g);
    ctx_t n;
    q_t   t;
    q_t   t2;
    n = c;
    if (k == K_SQ) begin
      n.p0 = sq64(c.ox);
      n.p1 = sq64(c.oy);
    end
    if (k == K_SA) begin
      n.sq0 = sqrt_init(c.p0 + c.p1);
      n.rs  = qadd(c.r0, c.r1);
    end
    if (k > K_SA && k <= K_SA + SQ_STEPS) begin
      n.sq0 = sqrt_step(c.sq0);
    end
    if (k == K_PEN) begin
      t     = root_val(c.sq0);
      t2    = qsub(c.rs, t);
      n.d   = t;
      n.pen = t2[31] ? '0 : t2;
      n.dpos = (t != '0);
      n.dv0 = div_init(mag32(c.ox), t, NB);
      n.dv1 = div_init(mag32(c.oy), t, NB);
    end
    if ((k > K_PEN && k <= K_PEN + NB) || (k > K_P3 && k <= K_P3 + NB)
        || (k > K_DD && k <= K_DD + XB)) begin
      n.dv0 = div_step(c.dv0);
      n.dv1 = div_step(c.dv1);
    end
    if (k == K_NRM) begin
      t    = {1'b0, c.pen[31:1]};
      n.nx = c.dpos ? div_val(c.ox[31], c.dv0) : '0;
      n.ny = c.dpos ? div_val(c.oy[31], c.dv1) : '0;
      n.l0 = qsub(c.r0, t);
      n.l1 = qsub(c.r1, t);
    end
    if (k == K_ARM) begin
      n.a0x = qmul(c.nx, c.l0);
      n.a0y = qmul(c.ny, c.l0);
      n.b0  = qmul(c.nx, c.l1);
      n.b1  = qmul(c.ny, c.l1);
    end
    if (k == K_ARN) begin
      n.a1x = qneg(c.b0);
      n.a1y = qneg(c.b1);
    end
    if (k == K_WMU) begin
      n.e0 = qmul(c.w0, c.a0y);
      n.e1 = qmul(c.w1, c.a1y);
      n.e2 = qmul(c.w0, c.a0x);
      n.e3 = qmul(c.w1, c.a1x);
    end
    if (k == K_RV) begin
      n.rvx = qadd(qsub(c.vx, c.e0), c.e1);
      n.rvy = qsub(qadd(c.vy, c.e2), c.e3);
    end
    if (k == K_RVM) begin
      n.f0 = qmul(c.nx, c.rvx);
      n.f1 = qmul(c.ny, c.rvy);
      n.f2 = qmul(g.dt, c.rvx);
      n.f3 = qmul(g.dt, c.rvy);
    end
    if (k == K_RN) begin
      n.rn = qadd(c.f0, c.f1);
      n.sx = qadd(c.sx, c.f2);
      n.sy = qadd(c.sy, c.f3);
    end
    if (k == K_VN) begin
      n.vnx = qmul(c.rn, c.nx);
      n.vny = qmul(c.rn, c.ny);
      n.g0  = qmul(c.nx, c.sx);
      n.g1  = qmul(c.ny, c.sy);
    end
    if (k == K_VT) begin
      n.vtx = qsub(c.rvx, c.vnx);
      n.vty = qsub(c.rvy, c.vny);
      n.sn  = qadd(c.g0, c.g1);
    end
    if (k == K_SP) begin
      n.h0 = qmul(c.sn, c.nx);
      n.h1 = qmul(c.sn, c.ny);
      n.kp = qmul(g.kn, c.pen);
    end
    if (k == K_SPJ) begin
      n.sx = qsub(c.sx, c.h0);
      n.sy = qsub(c.sy, c.h1);
    end
    if (k == K_FM) begin
      n.j0  = qmul(c.kp, c.nx);
      n.j1  = qmul(c.kp, c.ny);
      n.j2  = qmul(g.hgn, c.vnx);
      n.j3  = qmul(g.hgn, c.vny);
      n.j4  = qmul(g.kt, c.sx);
      n.j5  = qmul(g.kt, c.sy);
      n.hvx = qmul(g.hgt, c.vtx);
      n.hvy = qmul(g.hgt, c.vty);
    end
    if (k == K_F) begin
      n.fnx = qsub(qneg(c.j0), c.j2);
      n.fny = qsub(qneg(c.j1), c.j3);
      n.ffx = qsub(qneg(c.j4), c.hvx);
      n.ffy = qsub(qneg(c.j5), c.hvy);
    end
    if (k == K_FSQ) begin
      n.p0 = sq64(c.fnx);
      n.p1 = sq64(c.fny);
      n.p2 = sq64(c.ffx);
      n.p3 = sq64(c.ffy);
      n.p4 = sq64(c.vtx);
      n.p5 = sq64(c.vty);
      n.o0 = qmul(c.fnx, c.nx);
      n.o1 = qmul(c.fny, c.ny);
      n.u0 = qmul(c.sx, c.sx);
      n.u1 = qmul(c.sy, c.sy);
      n.u2 = qmul(c.vtx, c.sx);
      n.u3 = qmul(c.vty, c.sy);
      n.u4 = qmul(c.vtx, c.vtx);
      n.u5 = qmul(c.vty, c.vty);
      n.u6 = qmul(c.fnx, c.fnx);
      n.u7 = qmul(c.fny, c.fny);
      n.k0 = qmul(g.kt, g.kt);
      n.k1 = qmul(g.kt, g.gt);
      n.k2 = qmul(g.gt, g.gt) >>> 2;
      n.k3 = qmul(g.mu, g.mu);
    end
    if (k == K_SB) begin
      t      = qadd(c.o0, c.o1);
      n.sq0  = sqrt_init(c.p0 + c.p1);
      n.sq1  = sqrt_init(c.p2 + c.p3);
      n.sq2  = sqrt_init(c.p4 + c.p5);
      n.fneg = t[31];
      n.dss  = qadd(c.u0, c.u1);
      n.dvs  = qadd(c.u2, c.u3);
      n.dvv  = qadd(c.u4, c.u5);
      n.dff  = qadd(c.u6, c.u7);
    end
    if (k > K_SB && k <= K_SB + SQ_STEPS) begin
      n.sq0 = sqrt_step(c.sq0);
      n.sq1 = sqrt_step(c.sq1);
      n.sq2 = sqrt_step(c.sq2);
    end
    if (k == K_P1) begin
      t      = root_val(c.sq2);
      n.ft   = root_val(c.sq1);
      n.nvt  = t;
      n.mraw = qmul(g.mu, root_val(c.sq0));
      n.hv   = qmul(g.hgt, t);
      n.qa   = qmul(c.k0, c.dss);
      n.qb   = qmul(c.k1, c.dvs);
      n.c1   = qmul(c.k2, c.dvv);
      n.c2   = qmul(c.k3, c.dff);
    end
    if (k == K_P2) begin
      t      = c.fneg ? c.mraw : '0;
      n.mufn = t;
      n.clr  = (c.hv > t);
      n.lim  = !(c.hv > t) && (c.ft > t);
      n.qc   = qsub(c.c1, c.c2);
    end
    if (k == K_P3) begin
      n.ac  = qmul(c.qa, c.qc);
      n.bb  = qmul(c.qb, c.qb);
      n.dv0 = div_init(mag32(c.vtx), c.nvt, NB);
      n.dv1 = div_init(mag32(c.vty), c.nvt, NB);
    end
    if (k == K_P4) begin
      n.ac2 = qadd(c.ac, c.ac);
    end
    if (k == K_P5) begin
      n.ac4 = qadd(c.ac2, c.ac2);
    end
    if (k == K_P6) begin
      t     = qsub(c.bb, c.ac4);
      n.sq0 = sqrt_init((t[31] || t == '0) ? 64'd0 : {16'b0, t, 16'b0});
    end
    if (k > K_P6 && k <= K_P6 + SQ_STEPS) begin
      n.sq0 = sqrt_step(c.sq0);
    end
    if (k == K_UX) begin
      n.ux = (c.nvt != '0) ? div_val(c.vtx[31], c.dv0) : '0;
      n.uy = (c.nvt != '0) ? div_val(c.vty[31], c.dv1) : '0;
    end
    if (k == K_CF) begin
      n.cfx = qmul(c.mufn, qneg(c.ux));
      n.cfy = qmul(c.mufn, qneg(c.uy));
    end
    if (k == K_DD) begin
      t      = qsub(root_val(c.sq0), c.qb);
      t2     = qadd(c.qa, c.qa);
      n.qpos = !c.qa[31] && (c.qa != '0);
      n.nsg  = t[31];
      n.dv0  = div_init(mag32(t), t2, XB);
    end
    if (k == K_X) begin
      n.xv = c.qpos ? div_val(c.nsg, c.dv0) : '0;
    end
    if (k == K_XS) begin
      n.lsx = qmul(c.xv, c.sx);
      n.lsy = qmul(c.xv, c.sy);
    end
    if (k == K_KT) begin
      n.y0 = qmul(g.kt, c.lsx);
      n.y1 = qmul(g.kt, c.lsy);
    end
    if (k == K_LF) begin
      n.lfx = qsub(qneg(c.y0), c.hvx);
      n.lfy = qsub(qneg(c.y1), c.hvy);
    end
    if (k == K_SEL) begin
      if (c.clr) begin
        n.sx  = '0;
        n.sy  = '0;
        n.ffx = c.cfx;
        n.ffy = c.cfy;
      end else if (c.lim) begin
        n.sx  = c.lsx;
        n.sy  = c.lsy;
        n.ffx = c.lfx;
        n.ffy = c.lfy;
      end
    end
    if (k == K_T) begin
      n.tx = qadd(c.fnx, c.ffx);
      n.ty = qadd(c.fny, c.ffy);
    end
    if (k == K_TM) begin
      n.z0 = qmul(c.a0x, c.ty);
      n.z1 = qmul(c.a0y, c.tx);
      n.z2 = qmul(c.a1x, c.ty);
      n.z3 = qmul(c.a1y, c.tx);
    end
    if (k == K_TQ) begin
      n.tq0 = qsub(c.z0, c.z1);
      n.tq1 = qneg(qsub(c.z2, c.z3));
    end
    return n;
  endfunction

endpackage

@@ rtl/contact_force_with_coulomb_friction.sv @@
// ============================================================================
// contact_force_with_coulomb_friction
// Spring-dashpot contact force with Coulomb friction for one pair of disks.
// ============================================================================
// One contact enters per clock as long as the result side keeps taking
// transfers. The pipeline is built around three 32-step square root passes
// (center distance; force and velocity norms; the friction quadratic), two
// 17-step dividers for the contact normal and the sliding unit vector, and a
// 32-step divider for the slip scale, each retiring one bit per stage. All
// arithmetic is saturating signed Q16.16. The whole pipeline holds when a
// finished result waits and m_tready is low. Write the configuration
// registers only while no contact is in flight.
module contact_force_with_coulomb_friction (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // offset_x, offset_y, radius_first(31), radius_second(31), relvel_x,
  // relvel_y, spin_first, spin_second, slip_in_x, slip_in_y, 2 zero bits
  input  logic [319:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // force_x, force_y, torque_first, torque_second, slip_out_x, slip_out_y
  output logic [191:0] m_tdata,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int N = cfcf_pkg::N_OPS;

  logic [30:0] kn, gn, kt, gt, mu, dt;
  cfcf_pkg::cfg_t cf;

  cfcf_pkg::ctx_t ctx [0:N];
  cfcf_pkg::ctx_t ctx_next [1:N];
  cfcf_pkg::ctx_t ctx_in;
  logic [N:0] v;
  logic adv;

  // Hold every stage while the result register is full and not taken
  assign adv      = !v[N] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v[N];
  assign m_tdata  = {ctx[N].sy, ctx[N].sx, ctx[N].tq1, ctx[N].tq0, ctx[N].ty, ctx[N].tx};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kn <= '0;
      gn <= '0;
      kt <= '0;
      gt <= '0;
      mu <= '0;
      dt <= cfcf_pkg::DT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        cfcf_pkg::REG_KN: kn <= cfg_data;
        cfcf_pkg::REG_GN: gn <= cfg_data;
        cfcf_pkg::REG_KT: kt <= cfg_data;
        cfcf_pkg::REG_GT: gt <= cfg_data;
        cfcf_pkg::REG_MU: mu <= cfg_data;
        cfcf_pkg::REG_DT: dt <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cf.kn  = {1'b0, kn};
    cf.gn  = {1'b0, gn};
    cf.kt  = {1'b0, kt};
    cf.gt  = {1'b0, gt};
    cf.mu  = {1'b0, mu};
    cf.dt  = {1'b0, dt};
    cf.hgn = {2'b0, gn[30:1]};
    cf.hgt = {2'b0, gt[30:1]};
  end

  // Unpack the input transfer into the first context
  always_comb begin
    ctx_in    = '0;
    ctx_in.ox = s_tdata[31:0];
    ctx_in.oy = s_tdata[63:32];
    ctx_in.r0 = {1'b0, s_tdata[94:64]};
    ctx_in.r1 = {1'b0, s_tdata[125:95]};
    ctx_in.vx = s_tdata[157:126];
    ctx_in.vy = s_tdata[189:158];
    ctx_in.w0 = s_tdata[221:190];
    ctx_in.w1 = s_tdata[253:222];
    ctx_in.sx = s_tdata[285:254];
    ctx_in.sy = s_tdata[317:286];
  end

  // Each stage does a fixed part of the work, selected by its position
  always_comb begin
    for (int k = 0; k < N; k++) begin
      ctx_next[k+1] = cfcf_pkg::stage_op(k, ctx[k], cf);
    end
  end

  // Payload stages, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0] <= ctx_in;
      for (int k = 1; k <= N; k++) begin
        ctx[k] <= ctx_next[k];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[N-1:0], s_tvalid};
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> v == $past(v))
    else $error("pipeline moved during a stall");

  a_pen_nonneg: assert property (@(posedge clk) disable iff (rst)
    v[cfcf_pkg::K_PEN+1] |-> !ctx[cfcf_pkg::K_PEN+1].pen[31])
    else $error("negative penetration");

  a_case_excl: assert property (@(posedge clk) disable iff (rst)
    v[cfcf_pkg::K_P2+1] |-> !(ctx[cfcf_pkg::K_P2+1].clr && ctx[cfcf_pkg::K_P2+1].lim))
    else $error("both friction cases selected");

  a_limit_nonneg: assert property (@(posedge clk) disable iff (rst)
    v[cfcf_pkg::K_P2+1] |-> !ctx[cfcf_pkg::K_P2+1].mufn[31])
    else $error("negative friction limit");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the disk contact force pipeline
// Streams contacts into the block, predicts each force, torque and slip
// result in saturating Q16.16, and compares every output transfer in order.
// Sweeps several gain settings, stalls both sides at random, and holds the
// result side off long enough to back the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int PIPE_CYCLES = 178;
  localparam int HOLD_CYCLES = 600;

  // one contact as it travels on s_tdata
  typedef struct {
    logic signed [31:0] ox, oy;
    logic [30:0]        r0, r1;
    logic signed [31:0] vx, vy, w0, w1, sx, sy;
  } contact_t;

  // one result as it travels on m_tdata
  typedef struct {
    longint fx, fy, tq0, tq1, sx, sy;
  } contact_force_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // offset_x, offset_y, radius_first(31), radius_second(31), relvel_x,
  // relvel_y, spin_first, spin_second, slip_in_x, slip_in_y, 2 zero bits
  logic [319:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // force_x, force_y, torque_first, torque_second, slip_out_x, slip_out_y
  logic [191:0] m_tdata;
  logic         cfg_wen;
  logic [2:0]   cfg_index;
  logic [30:0]  cfg_data;

  // shadow copy of the gain registers
  longint kn, gn, kt, gt, mu, dt;

  contact_force_t pending_forces[$];
  int mismatches;
  int contacts_sent;
  int forces_checked;
  int burst_left;
  int hold_requests;
  int hold_served;
  int hold_left;
  int rx_mode;
  int rx_count;

  contact_force_with_coulomb_friction u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Saturating Q16.16 arithmetic, computed with exact wide intermediates
  // --------------------------------------------------------------------------
  function automatic longint clamp_word(longint x);
    if (x > WMAX) return WMAX;
    if (x < WMIN) return WMIN;
    return x;
  endfunction

  function automatic longint from_magnitude(bit neg, logic [127:0] m);
    if (!neg) return (m > 128'd2147483647) ? WMAX : longint'(m[63:0]);
    if (m >= 128'd2147483648) return WMIN;
    return -longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] magnitude(longint x);
    return (x < 0) ? 128'(-x) : 128'(x);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  function automatic longint fx_neg(longint a);
    return clamp_word(-a);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = magnitude(a) * magnitude(b);
    return from_magnitude((a < 0) != (b < 0), p >> 16);
  endfunction

  // quotient truncates toward zero; a zero divisor yields zero
  function automatic longint fx_div(longint a, longint b);
    logic [127:0] q;
    if (b == 0) return 0;
    q = (magnitude(a) << 16) / magnitude(b);
    return from_magnitude((a < 0) != (b < 0), q);
  endfunction

  function automatic logic [127:0] floor_root(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic longint fx_norm(longint x, longint y);
    return from_magnitude(1'b0,
      floor_root(magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y)));
  endfunction

  function automatic longint fx_sqrt(longint v);
    if (v <= 0) return 0;
    return from_magnitude(1'b0, floor_root(magnitude(v) << 16));
  endfunction

  function automatic longint fx_dot(longint ax, longint ay, longint bx, longint by);
    return fx_add(fx_mul(ax, bx), fx_mul(ay, by));
  endfunction

  // --------------------------------------------------------------------------
  // Force on one contact pair
  // --------------------------------------------------------------------------
  function automatic contact_force_t predict_contact(contact_t c);
    contact_force_t res;
    longint ox, oy, r0, r1, vx, vy, w0, w1, sx, sy;
    longint d, pen, nx, ny, hp, l0, l1, a0x, a0y, a1x, a1y;
    longint rvx, rvy, rn, vnx, vny, vtx, vty, sn, kp, hgn, hgt;
    longint fnx, fny, ffx, ffy, mufn, ft, nvt, tx, ty;
    longint qa, qb, qc, xs, ac, ac4, disc;
    ox = c.ox; oy = c.oy; r0 = c.r0; r1 = c.r1;
    vx = c.vx; vy = c.vy; w0 = c.w0; w1 = c.w1; sx = c.sx; sy = c.sy;
    nx = 0; ny = 0; mufn = 0;

    // penetration and contact normal; coincident centers leave the normal at zero
    d = fx_norm(ox, oy);
    pen = fx_sub(fx_add(r0, r1), d);
    if (pen < 0) pen = 0;
    if (d > 0) begin
      nx = fx_div(ox, d);
      ny = fx_div(oy, d);
    end
    hp = pen >>> 1;
    l0 = fx_sub(r0, hp);
    l1 = fx_sub(r1, hp);
    a0x = fx_mul(nx, l0);
    a0y = fx_mul(ny, l0);
    a1x = fx_neg(fx_mul(nx, l1));
    a1y = fx_neg(fx_mul(ny, l1));

    // relative velocity at the contact point, split into normal and tangent
    rvx = fx_add(fx_sub(vx, fx_mul(w0, a0y)), fx_mul(w1, a1y));
    rvy = fx_sub(fx_add(vy, fx_mul(w0, a0x)), fx_mul(w1, a1x));
    rn = fx_dot(nx, ny, rvx, rvy);
    vnx = fx_mul(rn, nx);
    vny = fx_mul(rn, ny);
    vtx = fx_sub(rvx, vnx);
    vty = fx_sub(rvy, vny);

    // advance the slip, then drop its normal part
    sx = fx_add(sx, fx_mul(dt, rvx));
    sy = fx_add(sy, fx_mul(dt, rvy));
    sn = fx_dot(nx, ny, sx, sy);
    sx = fx_sub(sx, fx_mul(sn, nx));
    sy = fx_sub(sy, fx_mul(sn, ny));

    kp = fx_mul(kn, pen);
    hgn = gn >>> 1;
    hgt = gt >>> 1;
    fnx = fx_sub(fx_neg(fx_mul(kp, nx)), fx_mul(hgn, vnx));
    fny = fx_sub(fx_neg(fx_mul(kp, ny)), fx_mul(hgn, vny));
    ffx = fx_sub(fx_neg(fx_mul(kt, sx)), fx_mul(hgt, vtx));
    ffy = fx_sub(fx_neg(fx_mul(kt, sy)), fx_mul(hgt, vty));

    // friction limit exists only for a compressive normal force
    if (fx_dot(fnx, fny, nx, ny) < 0) mufn = fx_mul(mu, fx_norm(fnx, fny));
    ft = fx_norm(ffx, ffy);
    nvt = fx_norm(vtx, vty);

    if (fx_mul(hgt, nvt) > mufn) begin
      // sliding: clear the slip, friction opposes the tangential velocity
      sx = 0; sy = 0; ffx = 0; ffy = 0;
      if (nvt > 0) begin
        ffx = fx_mul(mufn, fx_neg(fx_div(vtx, nvt)));
        ffy = fx_mul(mufn, fx_neg(fx_div(vty, nvt)));
      end
    end else if (ft > mufn) begin
      // sticking past the cone: scale the slip by the positive quadratic root
      qa = fx_mul(fx_mul(kt, kt), fx_dot(sx, sy, sx, sy));
      qb = fx_mul(fx_mul(kt, gt), fx_dot(vtx, vty, sx, sy));
      qc = fx_sub(fx_mul(fx_mul(gt, gt) >>> 2, fx_dot(vtx, vty, vtx, vty)),
                  fx_mul(fx_mul(mu, mu), fx_dot(fnx, fny, fnx, fny)));
      xs = 0;
      if (qa > 0) begin
        ac = fx_mul(qa, qc);
        ac4 = fx_add(fx_add(ac, ac), fx_add(ac, ac));
        disc = fx_sub(fx_mul(qb, qb), ac4);
        xs = fx_div(fx_sub(fx_sqrt(disc), qb), fx_add(qa, qa));
      end
      sx = fx_mul(xs, sx);
      sy = fx_mul(xs, sy);
      ffx = fx_sub(fx_neg(fx_mul(kt, sx)), fx_mul(hgt, vtx));
      ffy = fx_sub(fx_neg(fx_mul(kt, sy)), fx_mul(hgt, vty));
    end

    tx = fx_add(fnx, ffx);
    ty = fx_add(fny, ffy);
    res.fx = tx;
    res.fy = ty;
    res.tq0 = fx_sub(fx_mul(a0x, ty), fx_mul(a0y, tx));
    res.tq1 = fx_neg(fx_sub(fx_mul(a1x, ty), fx_mul(a1y, tx)));
    res.sx = sx;
    res.sy = sy;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] around_zero(int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  function automatic contact_t random_contact();
    contact_t c;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 75) begin
      // touching disks of about unit size with moderate motion
      c.ox = around_zero(32'h0002_0000);
      c.oy = around_zero(32'h0002_0000);
      c.r0 = 31'($urandom_range(32'h0001_8000, 32'h0000_4000));
      c.r1 = 31'($urandom_range(32'h0001_8000, 32'h0000_4000));
      c.vx = around_zero(32'h0004_0000);
      c.vy = around_zero(32'h0004_0000);
      c.w0 = around_zero(32'h0004_0000);
      c.w1 = around_zero(32'h0004_0000);
      c.sx = around_zero(32'h0000_2000);
      c.sy = around_zero(32'h0000_2000);
      if (kind < 5) begin
        c.ox = '0;
        c.oy = '0;
      end
    end else begin
      // full-range words, saturation everywhere
      c.ox = $urandom; c.oy = $urandom;
      c.r0 = 31'($urandom); c.r1 = 31'($urandom);
      c.vx = $urandom; c.vy = $urandom;
      c.w0 = $urandom; c.w1 = $urandom;
      c.sx = $urandom; c.sy = $urandom;
    end
    return c;
  endfunction

  function automatic contact_t uniform_contact(logic signed [31:0] v, logic [30:0] r);
    contact_t c;
    c.ox = v; c.oy = v; c.r0 = r; c.r1 = r;
    c.vx = v; c.vy = v; c.w0 = v; c.w1 = v; c.sx = v; c.sy = v;
    return c;
  endfunction

  // Send one contact: random bursts and gaps, then wait for the transfer
  task automatic send_contact(contact_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, c.sy, c.sx, c.w1, c.w0, c.vy, c.vx, c.r1, c.r0, c.oy, c.ox};
    do @(posedge clk); while (!s_tready);
    pending_forces.push_back(predict_contact(c));
    contacts_sent++;
  endtask

  // Idle the input and let every outstanding result come back
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_forces.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      cfcf_pkg::REG_KN: kn = val;
      cfcf_pkg::REG_GN: gn = val;
      cfcf_pkg::REG_KT: kt = val;
      cfcf_pkg::REG_GT: gt = val;
      cfcf_pkg::REG_MU: mu = val;
      cfcf_pkg::REG_DT: dt = val;
      default: ;
    endcase
  endtask

  task automatic write_gains(logic [30:0] k_n, logic [30:0] g_n, logic [30:0] k_t,
                             logic [30:0] g_t, logic [30:0] m_u, logic [30:0] d_t);
    drain_pipeline();
    write_reg(cfcf_pkg::REG_KN, k_n);
    write_reg(cfcf_pkg::REG_GN, g_n);
    write_reg(cfcf_pkg::REG_KT, k_t);
    write_reg(cfcf_pkg::REG_GT, g_t);
    write_reg(cfcf_pkg::REG_MU, m_u);
    write_reg(cfcf_pkg::REG_DT, d_t);
  endtask

  task automatic send_random(int count);
    repeat (count) send_contact(random_contact());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset gains give pure kinematics; probe field extremes and special cases
  task automatic test_directed_extremes();
    contact_t c;
    send_contact(uniform_contact(32'sh0, 31'h0));
    send_contact(uniform_contact(32'sh7fff_ffff, 31'h7fff_ffff));
    send_contact(uniform_contact(32'sh8000_0000, 31'h7fff_ffff));
    write_gains(31'd65536000, 31'd655360, 31'd32768000, 31'd327680, 31'd32768, 31'd655);
    // coincident centers: normal vanishes
    c = uniform_contact(32'sh0001_0000, 31'h0001_0000);
    c.ox = '0; c.oy = '0;
    send_contact(c);
    // separated disks: penetration clamps at zero
    c = uniform_contact(32'sh0001_0000, 31'h0000_4000);
    c.ox = 32'sh0010_0000;
    send_contact(c);
    // head-on touch, no tangential motion, no slip
    c = uniform_contact(32'sh0, 31'h0001_0000);
    c.ox = 32'sh0001_c000;
    send_contact(c);
    // strong sideways sliding: slip is cleared
    c.vy = 32'sh0008_0000;
    send_contact(c);
    // large stored slip, slow motion: slip scaled back to the cone
    c.vy = 32'sh0000_0100;
    c.sy = 32'sh0000_8000;
    send_contact(c);
    // pulling apart: normal force not compressive, zero friction limit
    c.vx = 32'sh8000_0000;
    send_contact(c);
    // extreme spins and slip on a real contact
    c = uniform_contact(32'sh0, 31'h0001_0000);
    c.ox = 32'sh0001_8000; c.w0 = 32'sh7fff_ffff; c.w1 = 32'sh8000_0000;
    c.sx = 32'sh8000_0000; c.sy = 32'sh7fff_ffff;
    send_contact(c);
    c.r0 = 31'h7fff_ffff; c.oy = 32'sh8000_0000;
    send_contact(c);
    send_random(8);
  endtask

  // Typical gains, then the all-zero and all-max corners
  task automatic test_gain_corners();
    send_random(150);
    write_gains('0, '0, '0, '0, '0, '0);
    send_random(60);
    write_gains(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                31'h7fff_ffff, 31'h7fff_ffff);
    send_random(60);
  endtask

  // Low friction and high tangential stiffness favor the cone-scaling path
  task automatic test_friction_limit();
    write_gains(31'd6553600, 31'd65536, 31'd65536000, 31'd6554, 31'd3277, 31'd6554);
    send_random(150);
    write_gains(31'd655360, 31'd6553600, 31'd655360, 31'd6553600, 31'd131072, 31'd655);
    send_random(120);
  endtask

  // Random gains for every phase
  task automatic test_random_gains();
    repeat (3) begin
      write_gains(31'($urandom_range(32'd70000000)), 31'($urandom_range(32'd2000000)),
                  31'($urandom_range(32'd70000000)), 31'($urandom_range(32'd2000000)),
                  31'($urandom_range(32'd100000)), 31'($urandom_range(32'd20000)));
      send_random(50);
    end
  endtask

  // Hold the result side off while contacts keep arriving
  task automatic test_backpressure();
    hold_requests++;
    send_random(140);
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall patterns, a long hold on request, and the comparison
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      hold_served <= 0;
      hold_left   <= 0;
      rx_mode     <= 0;
      rx_count    <= 0;
    end else begin
      rx_count <= rx_count + 1;
      if (rx_count % 97 == 0) rx_mode <= $urandom_range(2);
      if (hold_requests != hold_served) begin
        hold_served <= hold_requests;
        hold_left   <= HOLD_CYCLES;
        m_tready    <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(1) == 1);
          default: m_tready <= (rx_count % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    contact_force_t exp_f;
    contact_force_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.fx  = $signed(m_tdata[31:0]);
      got.fy  = $signed(m_tdata[63:32]);
      got.tq0 = $signed(m_tdata[95:64]);
      got.tq1 = $signed(m_tdata[127:96]);
      got.sx  = $signed(m_tdata[159:128]);
      got.sy  = $signed(m_tdata[191:160]);
      if (pending_forces.size() == 0) begin
        $error("result transfer with no contact outstanding");
        mismatches++;
      end else begin
        exp_f = pending_forces.pop_front();
        forces_checked++;
        if (got.fx != exp_f.fx) begin
          $error("force_x: expected %0d, got %0d", exp_f.fx, got.fx);
          mismatches++;
        end
        if (got.fy != exp_f.fy) begin
          $error("force_y: expected %0d, got %0d", exp_f.fy, got.fy);
          mismatches++;
        end
        if (got.tq0 != exp_f.tq0) begin
          $error("torque_first: expected %0d, got %0d", exp_f.tq0, got.tq0);
          mismatches++;
        end
        if (got.tq1 != exp_f.tq1) begin
          $error("torque_second: expected %0d, got %0d", exp_f.tq1, got.tq1);
          mismatches++;
        end
        if (got.sx != exp_f.sx) begin
          $error("slip_out_x: expected %0d, got %0d", exp_f.sx, got.sx);
          mismatches++;
        end
        if (got.sy != exp_f.sy) begin
          $error("slip_out_y: expected %0d, got %0d", exp_f.sy, got.sy);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    contacts_sent = 0;
    forces_checked = 0;
    burst_left = 0;
    hold_requests = 0;
    kn = 0; gn = 0; kt = 0; gt = 0; mu = 0; dt = 655;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_gain_corners();
    test_friction_limit();
    test_random_gains();
    test_backpressure();

    drain_pipeline();
    repeat (PIPE_CYCLES + 20) @(posedge clk);
    $display("Covered %0d contacts over zero, max, typical, low-friction and random gains,",
             contacts_sent);
    $display("with input gaps, output stalls and a long output hold; %0d results checked.",
             forces_checked);
    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
